FILE: design/etpc_pkg.sv
// Shared types and constants for the escape-time pixel color block.
// No dependencies; compile first.
package etpc_pkg;

   localparam int POINT_W      = 32;   // Q15.16 grid coordinate and seed
   localparam int COLOR_W      = 8;
   localparam int ESC_W        = 5;
   localparam int FRAC_BITS    = 32;   // Z and C are Q31.32
   localparam int SEED_SHIFT   = FRAC_BITS - 16;
   localparam int Z_W          = 64;
   localparam int SQ_W         = 33;   // |Z| below the bailout fits here
   localparam int PROD_W       = 2 * SQ_W;
   localparam int HALF_W       = 32;
   localparam int ACC_W        = 96;   // bits of |Z|*|C| up to floor(K)
   localparam int DIV_STEPS    = 33;   // one per bit of 2^32
   localparam int STEP_W       = $clog2(DIV_STEPS);
   localparam int IDX_W        = 7;    // holds iteration counts up to 64
   localparam int MAX_ITERATIONS_DEF = 16;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_C,
      OP_ADD_C,
      OP_SQ_MUL,
      OP_SQ_ADD,
      OP_K_MUL,
      OP_K_ACC,
      OP_D_INIT,
      OP_D_STEP,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] part;    // partial product select for K
      logic       first;   // first remainder step shifts in the leading one
      logic       bounded; // point never escaped
   } dp_cmd_type;

   typedef struct packed {
      logic escape;        // |Z| >= 2 after this iteration
      logic out_free;      // result register can take a new result
   } dp_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_C,
      ST_ADD_C,
      ST_SQ_MUL,
      ST_SQ_ADD,
      ST_K_MUL,
      ST_K_ACC,
      ST_D_INIT,
      ST_D_STEP,
      ST_FINISH
   } ctrl_state_type;

endpackage

FILE: design/etpc_if.sv
// Valid/ready channel interfaces for grid points and pixel results.
// Depends on etpc_pkg.
interface etpc_req_if import etpc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [POINT_W-1:0]  point_x;
   logic signed [POINT_W-1:0]  point_y;

   modport source (output valid, output point_x, output point_y, input ready);
   modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface etpc_rsp_if import etpc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;
   logic [ESC_W-1:0]   escape_count;
   logic               inside_res;

   modport source (output valid, output red, output green, output blue,
                   output escape_count, output inside_res, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input escape_count, input inside_res, output ready);
endinterface

FILE: design/etpc_ctrl.sv
// Sequencer for the escape-time pixel block: iteration and step counters,
// issues datapath commands. Depends on etpc_pkg.
module etpc_ctrl import etpc_pkg::*; #(
   parameter int MAX_ITERATIONS = MAX_ITERATIONS_DEF,
   parameter int CNT_W          = $clog2(MAX_ITERATIONS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dp_stat_type      stat,
   output dp_cmd_type       cmd,
   output logic [CNT_W-1:0] iter
);

   localparam logic [CNT_W-1:0]  LAST_ITER = CNT_W'(MAX_ITERATIONS - 1);
   localparam logic [STEP_W-1:0] LAST_DIV  = STEP_W'(DIV_STEPS - 1);
   localparam logic [STEP_W-1:0] LAST_PART = STEP_W'(3);

   ctrl_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  iter_ff, iter_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              inside_ff, inside_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         iter_ff   <= '0;
         step_ff   <= '0;
         inside_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         iter_ff   <= iter_in;
         step_ff   <= step_in;
         inside_ff <= inside_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      iter_in     = iter_ff;
      step_in     = step_ff;
      inside_in   = inside_ff;
      req_ready   = 1'b0;
      cmd.op      = OP_NONE;
      cmd.part    = step_ff[1:0];
      cmd.first   = (step_ff == '0);
      cmd.bounded = inside_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               iter_in  = '0;
               state_in = ST_MUL_C;
            end
         end
         ST_MUL_C: begin
            cmd.op   = OP_MUL_C;
            state_in = ST_ADD_C;
         end
         ST_ADD_C: begin
            cmd.op   = OP_ADD_C;
            state_in = ST_SQ_MUL;
         end
         ST_SQ_MUL: begin
            cmd.op   = OP_SQ_MUL;
            state_in = ST_SQ_ADD;
         end
         ST_SQ_ADD: begin
            cmd.op = OP_SQ_ADD;
            if (stat.escape) begin
               inside_in = 1'b0;
               step_in   = '0;
               state_in  = ST_K_MUL;
            end else if (iter_ff == LAST_ITER) begin
               inside_in = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               iter_in  = iter_ff + 1'b1;
               state_in = ST_SQ_MUL;
            end
         end
         ST_K_MUL: begin
            cmd.op   = OP_K_MUL;
            state_in = ST_K_ACC;
         end
         ST_K_ACC: begin
            cmd.op = OP_K_ACC;
            if (step_ff == LAST_PART) begin
               state_in = ST_D_INIT;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_K_MUL;
            end
         end
         ST_D_INIT: begin
            cmd.op   = OP_D_INIT;
            step_in  = '0;
            state_in = ST_D_STEP;
         end
         ST_D_STEP: begin
            cmd.op = OP_D_STEP;
            if (step_ff == LAST_DIV) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.op   = OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign iter = iter_ff;

endmodule

FILE: design/etpc_dpath.sv
// Datapath: seed register, shared 33x33 multiplier, Z/C registers, 96-bit
// product accumulator, bit-serial remainder and result register. Depends on etpc_pkg.
module etpc_dpath import etpc_pkg::*; #(
   parameter int MAX_ITERATIONS = MAX_ITERATIONS_DEF,
   parameter int CNT_W          = $clog2(MAX_ITERATIONS + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [POINT_W-1:0]         csr_wr_data,
   input  dp_cmd_type                 cmd,
   input  logic [CNT_W-1:0]           iter,
   output dp_stat_type                stat,
   input  logic signed [POINT_W-1:0]  req_point_x,
   input  logic signed [POINT_W-1:0]  req_point_y,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [COLOR_W-1:0]         rsp_red,
   output logic [COLOR_W-1:0]         rsp_green,
   output logic [COLOR_W-1:0]         rsp_blue,
   output logic [ESC_W-1:0]           rsp_escape_count,
   output logic                       rsp_inside_res
);

   localparam logic [IDX_W-1:0] MAX_CODE = IDX_W'(MAX_ITERATIONS);

   function automatic logic [COLOR_W-1:0] shade(input logic [COLOR_W-1:0] b,
                                                input logic [IDX_W-1:0] idx);
      logic [COLOR_W:0] s;
      s = {1'b0, b} + (COLOR_W + 1)'(idx);
      return s[COLOR_W] ? {COLOR_W{1'b1}} : s[COLOR_W-1:0];
   endfunction

   logic signed [POINT_W-1:0] seed_ff;
   logic signed [POINT_W-1:0] px_ff, py_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [Z_W-1:0]            c_ff, z_ff;
   logic [ACC_W-1:0]          acc_ff;
   logic [HALF_W-1:0]         d_ff, rem_ff;
   logic                      rsp_valid_ff;
   logic [COLOR_W-1:0]        red_ff, green_ff, blue_ff;
   logic [ESC_W-1:0]          esc_ff;
   logic                      inside_ff;

   logic [SQ_W-1:0]   mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   logic [HALF_W-1:0] px_mag, py_mag;
   logic [Z_W-1:0]    z_mag, c_mag;
   logic [Z_W-1:0]    c_prod, seed_ext, c_sum, z_sum;
   logic [ACC_W-1:0]  acc_add;
   logic [HALF_W:0]   rem_shift, rem_diff;
   logic [HALF_W-1:0] val;
   logic [IDX_W-1:0]  idx_wide;
   logic              big_pos, big_neg;

   assign px_mag = px_ff[POINT_W-1] ? HALF_W'(-px_ff) : HALF_W'(px_ff);
   assign py_mag = py_ff[POINT_W-1] ? HALF_W'(-py_ff) : HALF_W'(py_ff);
   assign z_mag  = z_ff[Z_W-1] ? -z_ff : z_ff;
   assign c_mag  = c_ff[Z_W-1] ? -c_ff : c_ff;

   // one shared multiplier, operands picked by the current command
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_MUL_C: begin
            mul_a = {1'b0, px_mag};
            mul_b = {1'b0, py_mag};
         end
         OP_SQ_MUL: begin
            mul_a = z_mag[SQ_W-1:0];
            mul_b = z_mag[SQ_W-1:0];
         end
         OP_K_MUL: begin
            mul_a = {1'b0, cmd.part[1] ? z_mag[Z_W-1:HALF_W] : z_mag[HALF_W-1:0]};
            mul_b = {1'b0, cmd.part[0] ? c_mag[Z_W-1:HALF_W] : c_mag[HALF_W-1:0]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // C = px*py + seed, rescaled to the Z format; cannot overflow 64 bits
   assign c_prod   = (px_ff[POINT_W-1] ^ py_ff[POINT_W-1]) ? -prod_ff[Z_W-1:0]
                                                           : prod_ff[Z_W-1:0];
   assign seed_ext = Z_W'({{(Z_W - POINT_W - SEED_SHIFT){seed_ff[POINT_W-1]}},
                           seed_ff, {SEED_SHIFT{1'b0}}});
   assign c_sum    = c_prod + seed_ext;

   // Z*Z floor-shifted by the fraction width, then plus C
   assign z_sum = Z_W'(prod_ff[PROD_W-1:FRAC_BITS]) + c_ff;

   // bailout |Z| >= 2, i.e. Z >= 2^33 or Z <= -2^33
   assign big_pos = !z_sum[Z_W-1] && (|z_sum[Z_W-2:FRAC_BITS+1]);
   assign big_neg = z_sum[Z_W-1] && !((&z_sum[Z_W-1:FRAC_BITS+1]) &&
                                      (|z_sum[FRAC_BITS:0]));

   assign stat.escape   = big_pos || big_neg;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (cmd.part)
         2'd0:    acc_add = {{HALF_W{1'b0}}, prod_ff[Z_W-1:0]};
         2'd3:    acc_add = {prod_ff[HALF_W-1:0], {Z_W{1'b0}}};
         default: acc_add = {prod_ff[Z_W-1:0], {HALF_W{1'b0}}};
      endcase
   end

   // restoring remainder of 2^32 by d, one dividend bit per step
   assign rem_shift = {rem_ff, cmd.first};
   assign rem_diff  = rem_shift - {1'b0, d_ff};

   assign val      = (d_ff == '0) ? '0 : rem_ff;
   assign idx_wide = IDX_W'(iter);

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
         if (cmd.op == OP_FINISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op) inside
         OP_LOAD: begin
            px_ff <= req_point_x;
            py_ff <= req_point_y;
         end
         OP_MUL_C, OP_SQ_MUL, OP_K_MUL: begin
            prod_ff <= prod;
         end
         OP_ADD_C: begin
            c_ff   <= c_sum;
            z_ff   <= '0;
            acc_ff <= '0;
         end
         OP_SQ_ADD: begin
            z_ff <= z_sum;
         end
         OP_K_ACC: begin
            acc_ff <= acc_ff + acc_add;
         end
         OP_D_INIT: begin
            d_ff   <= acc_ff[ACC_W-1:Z_W] + 1'b1;
            rem_ff <= '0;
         end
         OP_D_STEP: begin
            if (rem_shift >= {1'b0, d_ff}) begin
               rem_ff <= rem_diff[HALF_W-1:0];
            end else begin
               rem_ff <= rem_shift[HALF_W-1:0];
            end
         end
         OP_FINISH: begin
            if (cmd.bounded) begin
               red_ff    <= '0;
               green_ff  <= '0;
               blue_ff   <= '0;
               esc_ff    <= MAX_CODE[ESC_W-1:0];
               inside_ff <= 1'b1;
            end else begin
               red_ff    <= shade(val[23:16], idx_wide);
               green_ff  <= shade(val[15:8], idx_wide);
               blue_ff   <= shade(val[7:0], idx_wide);
               esc_ff    <= idx_wide[ESC_W-1:0];
               inside_ff <= 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red          = red_ff;
   assign rsp_green        = green_ff;
   assign rsp_blue         = blue_ff;
   assign rsp_escape_count = esc_ff;
   assign rsp_inside_res   = inside_ff;

endmodule

FILE: design/escape_time_pixel_color.sv
// Escape-time pixel color: one point per transaction, handled one at a time.
// From accept to rsp valid: C is formed, then the squaring loop runs a multiply
// and an add per iteration; on escape at index k, |Z|*|C| is built on the shared
// multiplier, then a 33-step remainder; otherwise MAX_ITERATIONS iterations run.
// Next point can be taken in the cycle after the result enters the output register.
// Synchronous reset clears the seed to 0, the sequencer to idle and rsp valid.
module escape_time_pixel_color import etpc_pkg::*; #(
   parameter int MAX_ITERATIONS = MAX_ITERATIONS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   etpc_req_if.sink           req_chan,
   etpc_rsp_if.source         rsp_chan,
   input  logic               csr_wr_en,
   input  logic [POINT_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);

   dp_cmd_type       cmd;
   dp_stat_type      stat;
   logic [CNT_W-1:0] iter;

   etpc_ctrl #(
      .MAX_ITERATIONS (MAX_ITERATIONS),
      .CNT_W          (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd),
      .iter      (iter)
   );

   etpc_dpath #(
      .MAX_ITERATIONS (MAX_ITERATIONS),
      .CNT_W          (CNT_W)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .cmd              (cmd),
      .iter             (iter),
      .stat             (stat),
      .req_point_x      (req_chan.point_x),
      .req_point_y      (req_chan.point_y),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_red          (rsp_chan.red),
      .rsp_green        (rsp_chan.green),
      .rsp_blue         (rsp_chan.blue),
      .rsp_escape_count (rsp_chan.escape_count),
      .rsp_inside_res   (rsp_chan.inside_res)
   );

endmodule
